@@ hdl/bounded_int_deque_list_core_defines.svh @@
// assertion macros for the bounded integer deque core
// no dependencies; included by files that carry concurrent assertions
`ifndef BOUNDED_INT_DEQUE_LIST_CORE_DEFINES_SVH
`define BOUNDED_INT_DEQUE_LIST_CORE_DEFINES_SVH

// checked on every clock edge, reset included
`define BIDL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

// checked only while reset is released
`define BIDL_ASSERT_RUN(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`endif

@@ hdl/bidl_pkg.sv @@
// shared types and constants for the bounded integer deque core
// no dependencies
package bidl_pkg;

  localparam int unsigned OP_W  = 4;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 8;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned LEN_W = 9;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 4'd0,
    OP_PUSH_FRONT = 4'd1,
    OP_POP_BACK   = 4'd2,
    OP_POP_FRONT  = 4'd3,
    OP_READ_FRONT = 4'd4,
    OP_READ_BACK  = 4'd5,
    OP_FIND       = 4'd6,
    OP_READ_AT    = 4'd7,
    OP_DELETE_AT  = 4'd8,
    OP_LENGTH     = 4'd9,
    OP_CLEAR      = 4'd10
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RDWAIT,
    S_FIND,
    S_DELRD,
    S_DELSH
  } state_e;

  typedef enum logic [1:0] {
    RD_FRONT,
    RD_LAST,
    RD_POS,
    RD_NEXT
  } rd_src_e;

  typedef enum logic [1:0] {
    WR_BACK,
    WR_PREV,
    WR_IDXM1
  } wr_src_e;

  typedef enum logic [1:0] {
    DATA_ZERO,
    DATA_RAM,
    DATA_VALUE
  } data_sel_e;

  typedef struct packed {
    logic      load;
    logic      rd_en;
    rd_src_e   rd_src;
    logic      wr_en;
    wr_src_e   wr_src;
    logic      idx_clear;
    logic      idx_load;
    logic      idx_inc;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      clr;
    logic      front_inc;
    logic      front_dec;
    logic      res_ld;
    data_sel_e data_sel;
    logic      fin;
    status_e   fin_status;
    logic      fin_found;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic pos_ok;
    logic next_ok;
    logic match;
  } sts_t;

endpackage

@@ hdl/bidl_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module bidl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/bidl_ctrl.sv @@
// controller state machine for the bounded integer deque core
// depends on bidl_pkg
module bidl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  bidl_pkg::sts_t  sts_i,
  output bidl_pkg::cmd_t  cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  bidl_pkg::state_e state_q, state_d;
  bidl_pkg::cmd_t   cmd;
  logic             done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bidl_pkg::S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd.fin;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      bidl_pkg::S_IDLE: begin
        if (start_i) begin
          cmd.load = 1'b1;
          state_d  = bidl_pkg::S_DISPATCH;
        end
      end
      bidl_pkg::S_DISPATCH: begin
        // default: finish now with zero data
        cmd.fin        = 1'b1;
        cmd.fin_status = bidl_pkg::ST_OK;
        cmd.res_ld     = 1'b1;
        cmd.data_sel   = bidl_pkg::DATA_ZERO;
        state_d        = bidl_pkg::S_IDLE;
        case (sts_i.op)
          bidl_pkg::OP_PUSH_BACK: begin
            if (sts_i.full) begin
              cmd.fin_status = bidl_pkg::ST_FULL;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_src  = bidl_pkg::WR_BACK;
              cmd.cnt_inc = 1'b1;
            end
          end
          bidl_pkg::OP_PUSH_FRONT: begin
            if (sts_i.full) begin
              cmd.fin_status = bidl_pkg::ST_FULL;
            end else begin
              cmd.wr_en     = 1'b1;
              cmd.wr_src    = bidl_pkg::WR_PREV;
              cmd.cnt_inc   = 1'b1;
              cmd.front_dec = 1'b1;
            end
          end
          bidl_pkg::OP_POP_BACK, bidl_pkg::OP_READ_BACK: begin
            if (sts_i.empty) begin
              cmd.fin_status = bidl_pkg::ST_EMPTY;
            end else begin
              cmd.fin    = 1'b0;
              cmd.res_ld = 1'b0;
              cmd.rd_en  = 1'b1;
              cmd.rd_src = bidl_pkg::RD_LAST;
              state_d    = bidl_pkg::S_RDWAIT;
            end
          end
          bidl_pkg::OP_POP_FRONT, bidl_pkg::OP_READ_FRONT: begin
            if (sts_i.empty) begin
              cmd.fin_status = bidl_pkg::ST_EMPTY;
            end else begin
              cmd.fin    = 1'b0;
              cmd.res_ld = 1'b0;
              cmd.rd_en  = 1'b1;
              cmd.rd_src = bidl_pkg::RD_FRONT;
              state_d    = bidl_pkg::S_RDWAIT;
            end
          end
          bidl_pkg::OP_FIND: begin
            if (sts_i.empty) begin
              cmd.fin_status = bidl_pkg::ST_MISS;
            end else begin
              cmd.fin       = 1'b0;
              cmd.res_ld    = 1'b0;
              cmd.rd_en     = 1'b1;
              cmd.rd_src    = bidl_pkg::RD_FRONT;
              cmd.idx_clear = 1'b1;
              state_d       = bidl_pkg::S_FIND;
            end
          end
          bidl_pkg::OP_READ_AT: begin
            if (!sts_i.pos_ok) begin
              cmd.fin_status = bidl_pkg::ST_MISS;
            end else begin
              cmd.fin    = 1'b0;
              cmd.res_ld = 1'b0;
              cmd.rd_en  = 1'b1;
              cmd.rd_src = bidl_pkg::RD_POS;
              state_d    = bidl_pkg::S_RDWAIT;
            end
          end
          bidl_pkg::OP_DELETE_AT: begin
            if (!sts_i.pos_ok) begin
              cmd.fin_status = bidl_pkg::ST_MISS;
            end else begin
              cmd.fin      = 1'b0;
              cmd.res_ld   = 1'b0;
              cmd.rd_en    = 1'b1;
              cmd.rd_src   = bidl_pkg::RD_POS;
              cmd.idx_load = 1'b1;
              state_d      = bidl_pkg::S_DELRD;
            end
          end
          bidl_pkg::OP_CLEAR: begin
            cmd.clr = 1'b1;
          end
          default: begin
            // length and unused codes only report
          end
        endcase
      end
      bidl_pkg::S_RDWAIT: begin
        cmd.fin        = 1'b1;
        cmd.fin_status = bidl_pkg::ST_OK;
        cmd.res_ld     = 1'b1;
        cmd.data_sel   = bidl_pkg::DATA_RAM;
        if (sts_i.op == bidl_pkg::OP_POP_BACK) begin
          cmd.cnt_dec = 1'b1;
        end
        if (sts_i.op == bidl_pkg::OP_POP_FRONT) begin
          cmd.cnt_dec   = 1'b1;
          cmd.front_inc = 1'b1;
        end
        state_d = bidl_pkg::S_IDLE;
      end
      bidl_pkg::S_FIND: begin
        if (sts_i.match) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = bidl_pkg::ST_OK;
          cmd.fin_found  = 1'b1;
          cmd.res_ld     = 1'b1;
          cmd.data_sel   = bidl_pkg::DATA_VALUE;
          state_d        = bidl_pkg::S_IDLE;
        end else if (sts_i.next_ok) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_src  = bidl_pkg::RD_NEXT;
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.fin        = 1'b1;
          cmd.fin_status = bidl_pkg::ST_MISS;
          cmd.res_ld     = 1'b1;
          cmd.data_sel   = bidl_pkg::DATA_ZERO;
          state_d        = bidl_pkg::S_IDLE;
        end
      end
      bidl_pkg::S_DELRD: begin
        // removed entry is the result data
        cmd.res_ld   = 1'b1;
        cmd.data_sel = bidl_pkg::DATA_RAM;
        if (sts_i.next_ok) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_src  = bidl_pkg::RD_NEXT;
          cmd.idx_inc = 1'b1;
          state_d     = bidl_pkg::S_DELSH;
        end else begin
          cmd.cnt_dec    = 1'b1;
          cmd.fin        = 1'b1;
          cmd.fin_status = bidl_pkg::ST_OK;
          state_d        = bidl_pkg::S_IDLE;
        end
      end
      bidl_pkg::S_DELSH: begin
        // move the entry just read one slot toward the front
        cmd.wr_en  = 1'b1;
        cmd.wr_src = bidl_pkg::WR_IDXM1;
        if (sts_i.next_ok) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_src  = bidl_pkg::RD_NEXT;
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.cnt_dec    = 1'b1;
          cmd.fin        = 1'b1;
          cmd.fin_status = bidl_pkg::ST_OK;
          state_d        = bidl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bidl_pkg::S_IDLE;
      end
    endcase
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != bidl_pkg::S_IDLE);
  assign done_o = done_q;

endmodule

@@ hdl/bidl_dp.sv @@
// datapath for the bounded integer deque core: pointers, walk index, store, results
// depends on bidl_pkg and bidl_ram
module bidl_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bidl_pkg::cmd_t                      cmd_i,
  output bidl_pkg::sts_t                      sts_o,
  input  logic [bidl_pkg::OP_W-1:0]           operation_i,
  input  logic signed [bidl_pkg::VAL_W-1:0]   value_i,
  input  logic [bidl_pkg::POS_W-1:0]          position_i,
  output logic [bidl_pkg::ST_W-1:0]           status_o,
  output logic signed [bidl_pkg::VAL_W-1:0]   data_o,
  output logic [bidl_pkg::IDX_W-1:0]          found_index_o,
  output logic [bidl_pkg::LEN_W-1:0]          length_o,
  output logic                                is_empty_o
);

  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [bidl_pkg::OP_W-1:0]  op_q;
  logic [bidl_pkg::VAL_W-1:0] value_q;
  logic [bidl_pkg::POS_W-1:0] pos_q;
  logic [PW-1:0]              front_q, front_d;
  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              idx_q, idx_d;
  logic [bidl_pkg::ST_W-1:0]  status_q;
  logic [bidl_pkg::VAL_W-1:0] data_q;
  logic [bidl_pkg::IDX_W-1:0] found_q;

  logic [PW-1:0]              front_prev, front_next;
  logic [PW-1:0]              raddr, waddr;
  logic [bidl_pkg::VAL_W-1:0] wdata, rdata;
  logic [CW-1:0]              idx_plus1;

  // ring slot of an offset from the front; both terms stay below capacity
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[PW-1:0];
  endfunction

  assign idx_plus1  = idx_q + CW'(1);
  assign front_prev = (front_q == '0) ? PW'(CAPACITY - 1) : front_q - PW'(1);
  assign front_next = (front_q == PW'(CAPACITY - 1)) ? '0 : front_q + PW'(1);

  always_comb begin
    case (cmd_i.rd_src)
      bidl_pkg::RD_FRONT: raddr = front_q;
      bidl_pkg::RD_LAST:  raddr = slot_of(front_q, count_q - CW'(1));
      bidl_pkg::RD_POS:   raddr = slot_of(front_q, CW'(pos_q));
      bidl_pkg::RD_NEXT:  raddr = slot_of(front_q, idx_plus1);
      default:            raddr = front_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_src)
      bidl_pkg::WR_BACK: begin
        waddr = slot_of(front_q, count_q);
        wdata = value_q;
      end
      bidl_pkg::WR_PREV: begin
        waddr = front_prev;
        wdata = value_q;
      end
      bidl_pkg::WR_IDXM1: begin
        waddr = slot_of(front_q, idx_q - CW'(1));
        wdata = rdata;
      end
      default: begin
        waddr = front_q;
        wdata = value_q;
      end
    endcase
  end

  bidl_ram #(
    .WIDTH (bidl_pkg::VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.clr) begin
      count_d = '0;
    end else if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end

    front_d = front_q;
    if (cmd_i.clr) begin
      front_d = '0;
    end else if (cmd_i.front_dec) begin
      front_d = front_prev;
    end else if (cmd_i.front_inc) begin
      front_d = front_next;
    end

    idx_d = idx_q;
    if (cmd_i.idx_clear) begin
      idx_d = '0;
    end else if (cmd_i.idx_load) begin
      idx_d = CW'(pos_q);
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_plus1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      status_q <= bidl_pkg::ST_OK;
      data_q   <= '0;
      found_q  <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cmd_i.res_ld) begin
        case (cmd_i.data_sel)
          bidl_pkg::DATA_RAM:   data_q <= rdata;
          bidl_pkg::DATA_VALUE: data_q <= value_q;
          default:              data_q <= '0;
        endcase
      end
      if (cmd_i.fin) begin
        status_q <= cmd_i.fin_status;
        found_q  <= cmd_i.fin_found ? bidl_pkg::IDX_W'(idx_q) : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      value_q <= value_i;
      pos_q   <= position_i;
    end
  end

  assign sts_o.op      = bidl_pkg::op_e'(op_q);
  assign sts_o.full    = (count_q == CW'(CAPACITY));
  assign sts_o.empty   = (count_q == '0);
  assign sts_o.pos_ok  = (bidl_pkg::LEN_W'(pos_q) < bidl_pkg::LEN_W'(count_q));
  assign sts_o.next_ok = ((CW+1)'(idx_q) + (CW+1)'(1) < (CW+1)'(count_q));
  assign sts_o.match   = (rdata == value_q);

  assign status_o      = status_q;
  assign data_o        = data_q;
  assign found_index_o = found_q;
  assign length_o      = bidl_pkg::LEN_W'(count_q);
  assign is_empty_o    = (count_q == '0);

endmodule

@@ hdl/bounded_int_deque_list_core.sv @@
// Bounded deque of signed 32-bit entries with find, indexed read and indexed delete.
// An operation is taken when start_i is high and busy_o is low; its result is on the
// result ports for the single cycle in which done_o is high and cannot be held off.
// The next operation may be started in that same cycle. Entries live in a ring in
// one single-port-read ram whose reads are registered. Push, length, clear, unused codes
// and refused operations finish in the dispatch state; pop, read front, read back and
// read at also pass through the read wait state; a find reads entries from the front
// until one matches or the last entry is compared; delete at position p reads the entry
// at p, then moves each later entry one slot toward the front through the ram.
// Depends on bidl_pkg, bidl_ctrl, bidl_dp, bidl_ram and the defines header.
`include "bounded_int_deque_list_core_defines.svh"

module bounded_int_deque_list_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [bidl_pkg::OP_W-1:0]         operation_i,
  input  logic signed [bidl_pkg::VAL_W-1:0] value_i,
  input  logic [bidl_pkg::POS_W-1:0]        position_i,
  output logic                              done_o,
  output logic [bidl_pkg::ST_W-1:0]         status_o,
  output logic signed [bidl_pkg::VAL_W-1:0] data_o,
  output logic [bidl_pkg::IDX_W-1:0]        found_index_o,
  output logic [bidl_pkg::LEN_W-1:0]        length_o,
  output logic                              is_empty_o
);

  bidl_pkg::cmd_t cmd;
  bidl_pkg::sts_t sts;

  bidl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  bidl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .status_o      (status_o),
    .data_o        (data_o),
    .found_index_o (found_index_o),
    .length_o      (length_o),
    .is_empty_o    (is_empty_o)
  );

  `BIDL_ASSERT_ALWAYS(a_done_not_busy, clk_i,
    done_o |-> !busy_o, "result shown while a transaction is still in flight")
  `BIDL_ASSERT_RUN(a_len_bound, clk_i, rst_ni,
    length_o <= bidl_pkg::LEN_W'(CAPACITY), "length above capacity")
  `BIDL_ASSERT_RUN(a_start_busy, clk_i, rst_ni,
    (start_i && !busy_o) |=> busy_o, "accepted transaction did not raise busy")
  `BIDL_ASSERT_RUN(a_full_len, clk_i, rst_ni,
    (done_o && status_o == bidl_pkg::ST_FULL) |-> length_o == bidl_pkg::LEN_W'(CAPACITY),
    "full status while space remains")

endmodule
